@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define ASSERT_RST(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// clocked assertion that also holds through reset
`define ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

@@ rtl/pic_pkg.sv @@
`timescale 1ns / 1ps
// shared widths, types and register codes of the clamped pi controller
package pic_pkg;

   localparam int Q_WIDTH       = 24;
   localparam int GAIN_WIDTH    = 16;
   localparam int FRAC_SHIFT    = 12;
   localparam int ERR_WIDTH     = Q_WIDTH + 1;
   localparam int PROD_WIDTH    = GAIN_WIDTH + 1 + ERR_WIDTH;
   localparam int TERM_WIDTH    = PROD_WIDTH - 1 - FRAC_SHIFT;
   localparam int INT_SUM_WIDTH = TERM_WIDTH + 1;
   localparam int DRV_SUM_WIDTH = TERM_WIDTH + 2;
   localparam int CSR_IDX_WIDTH = 3;

   // register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] REG_TARGET = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_KP     = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_KI     = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_LIM_A  = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_LIM_B  = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_BIAS   = 3'd5;

   // register reset values
   localparam logic signed [Q_WIDTH-1:0]  RST_TARGET = 24'sd30720;
   localparam logic [GAIN_WIDTH-1:0]      RST_KP     = 16'd369;
   localparam logic [GAIN_WIDTH-1:0]      RST_KI     = 16'd123;
   localparam logic signed [Q_WIDTH-1:0]  RST_LIM_A  = 24'sd0;
   localparam logic signed [Q_WIDTH-1:0]  RST_LIM_B  = 24'sd46080;
   localparam logic signed [Q_WIDTH-1:0]  RST_BIAS   = 24'sd23040;

   typedef logic signed [Q_WIDTH-1:0]       q_type;
   typedef logic signed [ERR_WIDTH-1:0]     err_type;
   typedef logic signed [PROD_WIDTH-1:0]    prod_type;
   typedef logic signed [TERM_WIDTH-1:0]    term_q_type;
   typedef logic signed [INT_SUM_WIDTH-1:0] isum_type;
   typedef logic signed [DRV_SUM_WIDTH-1:0] dsum_type;

   // gain products of one sample, already truncated to q.8
   typedef struct packed {
      logic signed [TERM_WIDTH-1:0] kp_term;
      logic signed [TERM_WIDTH-1:0] ki_term;
   } term_type;

   // limit and offset settings seen by the integrator stage
   typedef struct packed {
      logic signed [Q_WIDTH-1:0] limit_first;
      logic signed [Q_WIDTH-1:0] limit_second;
      logic signed [Q_WIDTH-1:0] output_bias;
   } lim_type;

endpackage

@@ rtl/pic_gain_mult.sv @@
`timescale 1ns / 1ps
// error forming and the two gain multiplications
module pic_gain_mult (
   input  logic signed [pic_pkg::Q_WIDTH-1:0] target_position,
   input  logic signed [pic_pkg::Q_WIDTH-1:0] measurement,
   input  logic [pic_pkg::GAIN_WIDTH-1:0]     proportional_gain,
   input  logic [pic_pkg::GAIN_WIDTH-1:0]     integral_gain,
   output pic_pkg::term_type                  terms
);

   pic_pkg::err_type                 err;
   logic signed [pic_pkg::GAIN_WIDTH:0] kp_s;
   logic signed [pic_pkg::GAIN_WIDTH:0] ki_s;
   pic_pkg::prod_type                kp_prod;
   pic_pkg::prod_type                ki_prod;

   // exact error, one bit wider than a position
   assign err = pic_pkg::err_type'(target_position) - pic_pkg::err_type'(measurement);

   // unsigned gains as non-negative signed operands
   assign kp_s = {1'b0, proportional_gain};
   assign ki_s = {1'b0, integral_gain};

   assign kp_prod = pic_pkg::prod_type'(kp_s) * pic_pkg::prod_type'(err);
   assign ki_prod = pic_pkg::prod_type'(ki_s) * pic_pkg::prod_type'(err);

   // drop the low fraction bits: floor toward minus infinity
   assign terms.kp_term = kp_prod[pic_pkg::FRAC_SHIFT +: pic_pkg::TERM_WIDTH];
   assign terms.ki_term = ki_prod[pic_pkg::FRAC_SHIFT +: pic_pkg::TERM_WIDTH];

endmodule

@@ rtl/pic_integ.sv @@
`timescale 1ns / 1ps
// integrator register with clamp, and the clamped output sum
module pic_integ (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               update,
   input  pic_pkg::term_type                  terms,
   input  pic_pkg::lim_type                   lims,
   output logic signed [pic_pkg::Q_WIDTH-1:0] drive
);

   pic_pkg::q_type    integ_ff;
   pic_pkg::q_type    integ_in;
   pic_pkg::q_type    lim_a;
   pic_pkg::q_type    lim_b;
   pic_pkg::q_type    lim_lo;
   pic_pkg::q_type    lim_hi;
   pic_pkg::isum_type int_sum;
   pic_pkg::isum_type int_lo;
   pic_pkg::isum_type int_hi;
   pic_pkg::isum_type int_clamped;
   pic_pkg::dsum_type drv_sum;
   pic_pkg::dsum_type drv_lo;
   pic_pkg::dsum_type drv_hi;
   pic_pkg::dsum_type drv_clamped;

   // order the two limits
   assign lim_a  = lims.limit_first;
   assign lim_b  = lims.limit_second;
   assign lim_lo = (lim_a < lim_b) ? lim_a : lim_b;
   assign lim_hi = (lim_a < lim_b) ? lim_b : lim_a;

   // integrator update and clamp
   assign int_sum = pic_pkg::isum_type'(integ_ff) + pic_pkg::isum_type'(terms.ki_term);
   assign int_lo  = pic_pkg::isum_type'(lim_lo);
   assign int_hi  = pic_pkg::isum_type'(lim_hi);

   always_comb begin
      if (int_sum > int_hi) begin
         int_clamped = int_hi;
      end else if (int_sum < int_lo) begin
         int_clamped = int_lo;
      end else begin
         int_clamped = int_sum;
      end
   end

   assign integ_in = int_clamped[pic_pkg::Q_WIDTH-1:0];

   // output sum and clamp
   assign drv_sum = pic_pkg::dsum_type'(terms.kp_term) + pic_pkg::dsum_type'(integ_in)
                  + pic_pkg::dsum_type'(lims.output_bias);
   assign drv_lo  = pic_pkg::dsum_type'(lim_lo);
   assign drv_hi  = pic_pkg::dsum_type'(lim_hi);

   always_comb begin
      if (drv_sum > drv_hi) begin
         drv_clamped = drv_hi;
      end else if (drv_sum < drv_lo) begin
         drv_clamped = drv_lo;
      end else begin
         drv_clamped = drv_sum;
      end
   end

   assign drive = drv_clamped[pic_pkg::Q_WIDTH-1:0];

   // integrator state
   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
      end else if (update) begin
         integ_ff <= integ_in;
      end
   end

endmodule

@@ rtl/pi_controller_clamped.sv @@
`timescale 1ns / 1ps
// top level of the clamped pi position controller
// The block takes one measured position per clock cycle while req_stall is low and
// returns one clamped drive value per transaction, in order, through the products and
// response registers. The gain products are formed as the request is captured; the
// integrator add-and-clamp runs between the captured products and the response
// register, so samples follow back to back and the block sustains one transaction per
// cycle while the response side takes them. Settings must be written through the csr
// port only while no transaction is in flight; the block does not enforce it. Indexes
// six and seven are ignored. The integrator clears to zero on reset.
module pi_controller_clamped (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic signed [pic_pkg::Q_WIDTH-1:0]       req_measurement,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [pic_pkg::Q_WIDTH-1:0]       rsp_drive,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [pic_pkg::CSR_IDX_WIDTH-1:0]        csr_index,
   input  logic [pic_pkg::Q_WIDTH-1:0]              csr_data
);

   pic_pkg::q_type                  target_ff;
   logic [pic_pkg::GAIN_WIDTH-1:0]  kp_ff;
   logic [pic_pkg::GAIN_WIDTH-1:0]  ki_ff;
   pic_pkg::q_type                  lim_a_ff;
   pic_pkg::q_type                  lim_b_ff;
   pic_pkg::q_type                  bias_ff;

   pic_pkg::term_type               terms_in;
   pic_pkg::term_type               terms_ff;
   logic                            s1_valid_ff;
   logic                            s1_valid_in;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   pic_pkg::q_type                  rsp_drive_ff;
   pic_pkg::q_type                  drive_next;
   pic_pkg::lim_type                lims;
   logic                            out_free;
   logic                            advance;
   logic                            req_take;
   logic                            csr_take;

   // settings registers
   assign csr_ready = 1'b1;
   assign csr_take  = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= pic_pkg::RST_TARGET;
         kp_ff     <= pic_pkg::RST_KP;
         ki_ff     <= pic_pkg::RST_KI;
         lim_a_ff  <= pic_pkg::RST_LIM_A;
         lim_b_ff  <= pic_pkg::RST_LIM_B;
         bias_ff   <= pic_pkg::RST_BIAS;
      end else if (csr_take) begin
         case (csr_index)
            pic_pkg::REG_TARGET: target_ff <= csr_data;
            pic_pkg::REG_KP:     kp_ff     <= csr_data[pic_pkg::GAIN_WIDTH-1:0];
            pic_pkg::REG_KI:     ki_ff     <= csr_data[pic_pkg::GAIN_WIDTH-1:0];
            pic_pkg::REG_LIM_A:  lim_a_ff  <= csr_data;
            pic_pkg::REG_LIM_B:  lim_b_ff  <= csr_data;
            pic_pkg::REG_BIAS:   bias_ff   <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // pipeline flow control
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign s1_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = out_free ? s1_valid_ff : 1'b1;

   // gain products of the incoming sample
   pic_gain_mult u_mult (
      .target_position   (target_ff),
      .measurement       (req_measurement),
      .proportional_gain (kp_ff),
      .integral_gain     (ki_ff),
      .terms             (terms_in)
   );

   // integrator and output clamp
   assign lims.limit_first  = lim_a_ff;
   assign lims.limit_second = lim_b_ff;
   assign lims.output_bias  = bias_ff;

   pic_integ u_integ (
      .clock  (clock),
      .reset  (reset),
      .update (advance),
      .terms  (terms_ff),
      .lims   (lims),
      .drive  (drive_next)
   );

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         terms_ff <= terms_in;
      end
      if (advance) begin
         rsp_drive_ff <= drive_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = rsp_drive_ff;

endmodule

@@ rtl/pic_checker.sv @@
`timescale 1ns / 1ps
// port-level checker for the clamped pi controller, with its bind
`include "assert_macros.svh"

module pic_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [pic_pkg::Q_WIDTH-1:0]   rsp_drive
);

   // a stalled response stays offered with the same value
   `ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_drive))

   // no response is shown right after reset
   `ASSERT_ALWAYS(a_rst_empty, clock, reset |=> !rsp_valid)

   // the input is never stalled while the response side can move
   `ASSERT_ALWAYS(a_no_false_stall, clock, (!rsp_valid || !rsp_stall) |-> !req_stall)

   // an accepted transaction reaches the response register when the output drains
   `ASSERT_RST(a_latency, clock, reset, req_valid && !req_stall ##1 !rsp_stall |=> rsp_valid)

endmodule

bind pi_controller_clamped pic_checker u_pic_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_drive       (rsp_drive)
);

@@ verif/pi_controller_clamped_test.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the clamped pi position controller
module pi_controller_clamped_test;
   import pic_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 120;
   localparam int SETTLE_CYCLES  = 4;
   localparam int RANDOM_PHASES  = 10;
   localparam int PHASE_SAMPLES  = 70;
   localparam int PRESSURE_PHASE = 4;
   localparam int REPORT_LINES   = 50;

   // indexes with no register behind them
   localparam logic [CSR_IDX_WIDTH-1:0] REG_SPARE_6 = 3'd6;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_SPARE_7 = 3'd7;

   localparam q_type Q_MIN = 24'h800000;
   localparam q_type Q_MAX = 24'h7FFFFF;

   // settings styles of the random phases
   localparam int STYLE_MODERATE = 0;
   localparam int STYLE_EXTREME  = 1;
   localparam int STYLE_EQUAL    = 2;
   localparam int STYLE_WIDE     = 3;

   // expected drive values and the controller state behind them
   class drive_scoreboard;
      q_type                 target_position;
      logic [GAIN_WIDTH-1:0] prop_gain;
      logic [GAIN_WIDTH-1:0] int_gain;
      q_type                 limit_first;
      q_type                 limit_second;
      q_type                 output_bias;
      q_type                 integrator;
      q_type                 drive_queue[$];
      int                    mismatch_count;

      function new();
         target_position = RST_TARGET;
         prop_gain       = RST_KP;
         int_gain        = RST_KI;
         limit_first     = RST_LIM_A;
         limit_second    = RST_LIM_B;
         output_bias     = RST_BIAS;
         integrator      = '0;
         mismatch_count  = 0;
      endfunction

      function void set_register(logic [CSR_IDX_WIDTH-1:0] index, logic [Q_WIDTH-1:0] data);
         case (index)
            REG_TARGET: target_position = data;
            REG_KP:     prop_gain = data[GAIN_WIDTH-1:0];
            REG_KI:     int_gain = data[GAIN_WIDTH-1:0];
            REG_LIM_A:  limit_first = data;
            REG_LIM_B:  limit_second = data;
            REG_BIAS:   output_bias = data;
            default: ;
         endcase
      endfunction

      function q_type clamp_q(dsum_type value, q_type lo, q_type hi);
         if (value > dsum_type'(hi)) return hi;
         if (value < dsum_type'(lo)) return lo;
         return q_type'(value);
      endfunction

      // one controller step for an accepted measurement
      function void note_sample(q_type meas);
         err_type    err;
         prod_type   kp_prod;
         prod_type   ki_prod;
         term_q_type kp_term;
         term_q_type ki_term;
         dsum_type   sum;
         q_type      lo;
         q_type      hi;
         lo = (limit_first < limit_second) ? limit_first : limit_second;
         hi = (limit_first < limit_second) ? limit_second : limit_first;
         err = err_type'(target_position) - err_type'(meas);
         // arithmetic shift truncates toward minus infinity
         kp_prod = prod_type'($signed({1'b0, prop_gain})) * prod_type'(err);
         ki_prod = prod_type'($signed({1'b0, int_gain})) * prod_type'(err);
         kp_term = term_q_type'(kp_prod >>> FRAC_SHIFT);
         ki_term = term_q_type'(ki_prod >>> FRAC_SHIFT);
         sum = dsum_type'(integrator) + dsum_type'(ki_term);
         integrator = clamp_q(sum, lo, hi);
         sum = dsum_type'(kp_term) + dsum_type'(integrator) + dsum_type'(output_bias);
         drive_queue.push_back(clamp_q(sum, lo, hi));
      endfunction

      task report_mismatch(string msg);
         if (mismatch_count < REPORT_LINES) $display("mismatch at %0t ns: %s", $time, msg);
         mismatch_count++;
      endtask

      task check_drive(q_type drive);
         q_type want;
         if (drive_queue.size() == 0) begin
            report_mismatch($sformatf("drive %0d with no sample pending", drive));
         end else begin
            want = drive_queue.pop_front();
            if (drive !== want) report_mismatch($sformatf("drive %0d, expected %0d", drive, want));
         end
      endtask

      task check_drained();
         if (drive_queue.size() != 0)
            report_mismatch($sformatf("%0d drive values never arrived", drive_queue.size()));
      endtask
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   q_type                     req_measurement = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   q_type                     rsp_drive;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_WIDTH-1:0]  csr_index = '0;
   logic [Q_WIDTH-1:0]        csr_data = '0;

   drive_scoreboard sb;
   bit              hold_request = 1'b0;
   int              idle_cycles = 0;

   pi_controller_clamped DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_measurement (req_measurement),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_drive       (rsp_drive),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic q_type rand_span(int span);
      int v;
      v = int'($urandom_range(0, 2 * span)) - span;
      return q_type'(v);
   endfunction

   function automatic logic [GAIN_WIDTH-1:0] extreme_gain();
      case ($urandom_range(0, 2))
         0: return '0;
         1: return 16'd1;
         default: return 16'hFFFF;
      endcase
   endfunction

   // gains ride in the low bits; the upper bits are random filler
   function automatic logic [Q_WIDTH-1:0] gain_word(logic [GAIN_WIDTH-1:0] gain);
      return {8'($urandom_range(0, 255)), gain};
   endfunction

   function automatic q_type random_measurement();
      case ($urandom_range(0, 7))
         0: return q_type'($urandom());
         1: return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
         2, 3, 4, 5: return q_type'(int'(sb.target_position) + int'(rand_span(2048)));
         default: return q_type'(int'(sb.target_position) + int'(rand_span(200000)));
      endcase
   endfunction

   // one csr write transaction
   task automatic write_reg(logic [CSR_IDX_WIDTH-1:0] index, logic [Q_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      sb.set_register(index, data);
      @(posedge clock);
   endtask

   // one request transaction; valid stays high for a following item
   task automatic send_sample(q_type meas);
      req_valid       <= 1'b1;
      req_measurement <= meas;
      do @(posedge clock); while (req_stall);
      sb.note_sample(meas);
   endtask

   task automatic wait_until_idle();
      while (sb.drive_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // bursts of random length with random gaps, or back to back when steady
   task automatic run_samples(int count, bit steady);
      int burst;
      int gap;
      burst = $urandom_range(1, 24);
      for (int n = 0; n < count; n++) begin
         if (burst == 0) begin
            gap = steady ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst = $urandom_range(1, 24);
         end
         send_sample(random_measurement());
         burst--;
      end
      req_valid <= 1'b0;
   endtask

   task automatic pick_settings(int style);
      q_type                 tgt;
      q_type                 lim_a;
      q_type                 lim_b;
      q_type                 bias;
      logic [GAIN_WIDTH-1:0] kp;
      logic [GAIN_WIDTH-1:0] ki;
      tgt   = rand_span(1 << 20);
      kp    = 16'($urandom_range(0, 8192));
      ki    = 16'($urandom_range(0, 1024));
      lim_a = rand_span(1 << 21);
      lim_b = rand_span(1 << 21);
      bias  = rand_span(1 << 16);
      case (style)
         STYLE_EXTREME: begin
            tgt   = $urandom_range(0, 1) ? Q_MAX : Q_MIN;
            kp    = extreme_gain();
            ki    = extreme_gain();
            lim_a = $urandom_range(0, 1) ? Q_MAX : Q_MIN;
            lim_b = (lim_a == Q_MAX) ? Q_MIN : Q_MAX;
            bias  = $urandom_range(0, 1) ? Q_MAX : Q_MIN;
         end
         STYLE_EQUAL: begin
            lim_b = lim_a;
         end
         STYLE_WIDE: begin
            tgt   = q_type'($urandom());
            kp    = 16'($urandom_range(0, 65535));
            ki    = 16'($urandom_range(0, 65535));
            lim_a = q_type'($urandom());
            lim_b = q_type'($urandom());
            bias  = q_type'($urandom());
         end
         default: ;
      endcase
      write_reg(REG_TARGET, tgt);
      write_reg(REG_KP, gain_word(kp));
      write_reg(REG_KI, gain_word(ki));
      write_reg(REG_LIM_A, lim_a);
      write_reg(REG_LIM_B, lim_b);
      write_reg(REG_BIAS, bias);
      if ($urandom_range(0, 2) == 0)
         write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, 24'($urandom()));
   endtask

   // response side: check, random stall segments, and one long hold-off
   initial begin : receiver
      int seg_left;
      int stall_pct;
      int hold_left;
      seg_left  = 0;
      stall_pct = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) sb.check_drive(rsp_drive);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else begin
            if (seg_left == 0) begin
               seg_left = $urandom_range(5, 60);
               case ($urandom_range(0, 3))
                  0: stall_pct = 0;
                  1: stall_pct = 25;
                  2: stall_pct = 50;
                  default: stall_pct = 90;
               endcase
            end
            seg_left--;
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   initial begin : stimulus
      int style;
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // limits in swapped order, integrator at zero starts below them
      write_reg(REG_LIM_A, 24'd12800);
      write_reg(REG_LIM_B, 24'd2560);
      send_sample(Q_MIN);
      send_sample(Q_MAX);
      send_sample(q_type'(0));
      send_sample(RST_TARGET);
      send_sample(q_type'(1));
      req_valid <= 1'b0;
      wait_until_idle();

      // full-scale gains, limits and errors
      write_reg(REG_TARGET, Q_MAX);
      write_reg(REG_KP, 24'hFFFFFF);
      write_reg(REG_KI, 24'h00FFFF);
      write_reg(REG_LIM_A, Q_MAX);
      write_reg(REG_LIM_B, Q_MIN);
      write_reg(REG_BIAS, Q_MIN);
      send_sample(Q_MIN);
      send_sample(Q_MAX);
      send_sample(q_type'(0));
      req_valid <= 1'b0;
      wait_until_idle();
      write_reg(REG_TARGET, Q_MIN);
      write_reg(REG_BIAS, Q_MAX);
      send_sample(Q_MAX);
      send_sample(Q_MIN);
      req_valid <= 1'b0;
      wait_until_idle();

      // equal limits force integrator and drive
      write_reg(REG_LIM_A, q_type'(-1234));
      write_reg(REG_LIM_B, q_type'(-1234));
      repeat (3) send_sample(q_type'($urandom()));
      req_valid <= 1'b0;
      wait_until_idle();

      // zero gains, writes to unused indexes are dropped
      write_reg(REG_KP, 24'hAB0000);
      write_reg(REG_KI, 24'h000000);
      write_reg(REG_SPARE_6, 24'($urandom()));
      write_reg(REG_SPARE_7, 24'($urandom()));
      write_reg(REG_LIM_A, RST_LIM_B);
      write_reg(REG_LIM_B, RST_LIM_A);
      write_reg(REG_BIAS, RST_BIAS);
      repeat (3) send_sample(q_type'($urandom()));
      req_valid <= 1'b0;
      wait_until_idle();

      // tiny products, negative ones round toward minus infinity
      write_reg(REG_TARGET, 24'd0);
      write_reg(REG_KP, 24'd1);
      write_reg(REG_KI, 24'd1);
      write_reg(REG_BIAS, 24'd0);
      write_reg(REG_LIM_A, Q_MIN);
      write_reg(REG_LIM_B, Q_MAX);
      send_sample(q_type'(1));
      send_sample(q_type'(-1));
      send_sample(q_type'(3));
      send_sample(q_type'(-5000));
      req_valid <= 1'b0;

      // random phases, settings change only between them
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_until_idle();
         if (p == 0) style = STYLE_MODERATE;
         else if (p == 1) style = STYLE_EXTREME;
         else if (p == 2) style = STYLE_EQUAL;
         else style = $urandom_range(STYLE_MODERATE, STYLE_WIDE);
         pick_settings(style);
         if (p == PRESSURE_PHASE) begin
            // receiver holds off while requests keep coming
            hold_request = 1'b1;
            run_samples(PHASE_SAMPLES, 1'b1);
         end else begin
            run_samples(PHASE_SAMPLES, 1'b0);
         end
      end

      wait_until_idle();
      sb.check_drained();
      if (sb.mismatch_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
